// ----- sv/sm4_ctr_cipher_defines.svh -----
// Assertion macros for the SM4 counter-mode checker.
`ifndef SM4_CTR_CIPHER_DEFINES_SVH
`define SM4_CTR_CIPHER_DEFINES_SVH

// Clocked assertion, inactive while reset is high.
`define SM4C_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SM4C_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sm4c_pkg.sv -----
// Shared types, constants and the SM4 S-box for the SM4 counter-mode cipher.
package sm4c_pkg;

   localparam int ROUND_COUNT = 32;
   localparam int KEY_SLOTS   = 32;
   localparam int KEY_IDX_W   = $clog2(KEY_SLOTS);
   localparam int WORD_W      = 32;
   localparam int BLOCK_W     = 4 * WORD_W;
   localparam int CFG_W       = 64;
   localparam int COUNT_W     = 5;
   localparam int CHUNK_BYTES = 16;
   localparam int REQ_DATA_W  = 176;
   localparam int RSP_DATA_W  = 136;

   typedef enum logic {
      OP_KEY_LOAD = 1'b0,
      OP_DATA     = 1'b1
   } op_type;

   typedef enum logic {
      CSR_COUNTER_INIT_HIGH = 1'b0,
      CSR_COUNTER_INIT_LOW  = 1'b1
   } csr_index_type;

   // Write request into the round key store.
   typedef struct packed {
      logic                 en;
      logic [KEY_IDX_W-1:0] addr;
      logic [WORD_W-1:0]    data;
   } key_wr_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   function automatic logic [7:0] sbox_lookup(input logic [7:0] a);
      return SBOX[a];
   endfunction

endpackage

// ----- sv/sm4c_key_store.sv -----
// Round key store: one write port, one registered read port.
module sm4c_key_store
   import sm4c_pkg::*;
(
   input  logic                 clock,
   input  key_wr_type           wr,
   input  logic [KEY_IDX_W-1:0] rd_addr,
   output logic [WORD_W-1:0]    rd_data
);

   logic [WORD_W-1:0] mem [KEY_SLOTS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sm4c_round.sv -----
// One SM4 round: S-box layer, linear diffusion and word rotation of the block.
module sm4c_round
   import sm4c_pkg::*;
(
   input  logic [BLOCK_W-1:0] blk,
   input  logic [WORD_W-1:0]  round_key,
   output logic [BLOCK_W-1:0] blk_next
);

   logic [WORD_W-1:0] x0, x1, x2, x3;
   logic [WORD_W-1:0] mix, subst, diff;

   assign x0 = blk[4*WORD_W-1 -: WORD_W];
   assign x1 = blk[3*WORD_W-1 -: WORD_W];
   assign x2 = blk[2*WORD_W-1 -: WORD_W];
   assign x3 = blk[WORD_W-1:0];

   assign mix = x1 ^ x2 ^ x3 ^ round_key;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         subst[8*i +: 8] = sbox_lookup(mix[8*i +: 8]);
      end
   end

   assign diff = subst
               ^ {subst[WORD_W-3:0],  subst[WORD_W-1 -: 2]}
               ^ {subst[WORD_W-11:0], subst[WORD_W-1 -: 10]}
               ^ {subst[WORD_W-19:0], subst[WORD_W-1 -: 18]}
               ^ {subst[WORD_W-25:0], subst[WORD_W-1 -: 24]};

   // Shift the window left by one word; the new word enters at the bottom.
   assign blk_next = {x1, x2, x3, x0 ^ diff};

endmodule

// ----- sv/sm4_ctr_cipher.sv -----
// SM4 counter-mode cipher: each data transfer is XORed with the SM4 encryption
// of a 128-bit big-endian counter, which then increments modulo 2^128; the
// first_chunk flag reloads the counter from the two counter_init registers.
// A key load transfer (req_tuser = 0) writes one of the 32 round keys. A data
// transfer is accepted while the first round key is fetched, then steps through
// the rounds in the single shared round unit with each key read from the key
// store a round ahead, and finally masks and registers the result once the
// output register is free. A data transfer with a byte count of zero skips the
// rounds and returns an all-zero result without advancing the counter. Counts
// above 16 saturate to 16. The next transfer is accepted while a finished result
// still waits on rsp_tready. Round keys must be loaded before the first data
// transfer that uses them.
module sm4_ctr_cipher
   import sm4c_pkg::*;
#(
   parameter int ROUND_COUNT = sm4c_pkg::ROUND_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key_index, key_word, data_high, data_low, byte_count, first_chunk, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_high, result_low, result_bytes, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int RND_W = $clog2(ROUND_COUNT);
   localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH
   } state_type;

   // Request fields.
   logic [KEY_IDX_W-1:0] req_key_index;
   logic [WORD_W-1:0]    req_key_word;
   logic [BLOCK_W-1:0]   req_data;
   logic [COUNT_W-1:0]   req_byte_count;
   logic                 req_first_chunk;
   logic [COUNT_W-1:0]   req_count_sat;

   assign req_key_index   = req_tdata[4:0];
   assign req_key_word    = req_tdata[36:5];
   assign req_data        = {req_tdata[100:37], req_tdata[164:101]};
   assign req_byte_count  = req_tdata[169:165];
   assign req_first_chunk = req_tdata[170];
   assign req_count_sat   = (req_byte_count > COUNT_W'(CHUNK_BYTES)) ?
                            COUNT_W'(CHUNK_BYTES) : req_byte_count;

   state_type            state_ff, state_in;
   logic [RND_W-1:0]     round_ff, round_in;
   logic [BLOCK_W-1:0]   blk_ff, blk_in;
   logic [BLOCK_W-1:0]   data_ff, data_in;
   logic [COUNT_W-1:0]   nbytes_ff, nbytes_in;
   logic [BLOCK_W-1:0]   ctr_ff, ctr_in;
   logic [CFG_W-1:0]     init_hi_ff, init_hi_in;
   logic [CFG_W-1:0]     init_lo_ff, init_lo_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_xfer;
   logic [RND_W-1:0]     round_next;
   key_wr_type           key_wr;
   logic [KEY_IDX_W-1:0] key_rd_addr;
   logic [WORD_W-1:0]    key_rd_data;
   logic [BLOCK_W-1:0]   blk_round;
   logic [BLOCK_W-1:0]   keystream;
   logic [BLOCK_W-1:0]   byte_mask;
   logic [BLOCK_W-1:0]   result;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign round_next = round_ff + 1'b1;

   assign key_wr.en   = req_xfer && (op_type'(req_tuser) == OP_KEY_LOAD);
   assign key_wr.addr = req_key_index;
   assign key_wr.data = req_key_word;

   // Fetch the key one round ahead; round zero is fetched while idle.
   assign key_rd_addr = (state_ff == ST_ROUND) ? round_next[KEY_IDX_W-1:0] : '0;

   sm4c_key_store u_key_store (
      .clock   (clock),
      .wr      (key_wr),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   sm4c_round u_round (
      .blk       (blk_ff),
      .round_key (key_rd_data),
      .blk_next  (blk_round)
   );

   // Final output word order is reversed: {x3, x2, x1, x0}.
   assign keystream = {blk_ff[WORD_W-1:0], blk_ff[2*WORD_W-1 -: WORD_W],
                       blk_ff[3*WORD_W-1 -: WORD_W], blk_ff[4*WORD_W-1 -: WORD_W]};

   always_comb begin
      for (int i = 0; i < CHUNK_BYTES; i++) begin
         byte_mask[BLOCK_W-1-8*i -: 8] = (COUNT_W'(i) < nbytes_ff) ? 8'hff : 8'h00;
      end
   end

   assign result = (data_ff ^ keystream) & byte_mask;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      blk_in       = blk_ff;
      data_in      = data_ff;
      nbytes_in    = nbytes_ff;
      ctr_in       = ctr_ff;
      init_hi_in   = init_hi_ff;
      init_lo_in   = init_lo_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COUNTER_INIT_HIGH: init_hi_in = csr_wdata;
            CSR_COUNTER_INIT_LOW:  init_lo_in = csr_wdata;
            default:               init_lo_in = init_lo_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (op_type'(req_tuser) == OP_DATA)) begin
               if (req_first_chunk) begin
                  ctr_in = {init_hi_ff, init_lo_ff};
                  blk_in = {init_hi_ff, init_lo_ff};
               end else begin
                  blk_in = ctr_ff;
               end
               data_in   = req_data;
               nbytes_in = req_count_sat;
               round_in  = '0;
               state_in  = (req_count_sat == '0) ? ST_FINISH : ST_ROUND;
            end
         end
         ST_ROUND: begin
            blk_in   = blk_round;
            round_in = round_next;
            if (round_ff == LAST_ROUND) begin
               ctr_in   = ctr_ff + 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, nbytes_ff,
                               result[CFG_W-1:0], result[BLOCK_W-1 -: CFG_W]};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ctr_ff       <= '0;
         init_hi_ff   <= '0;
         init_lo_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ctr_ff       <= ctr_in;
         init_hi_ff   <= init_hi_in;
         init_lo_ff   <= init_lo_in;
      end
      round_ff    <= round_in;
      blk_ff      <= blk_in;
      data_ff     <= data_in;
      nbytes_ff   <= nbytes_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- sv/sm4c_checker.sv -----
// Port-level checks for the SM4 counter-mode cipher, bound to the top level.
`include "sm4_ctr_cipher_defines.svh"

module sm4c_checker
   import sm4c_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `SM4C_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   `SM4C_ASSERT(a_busy_after_data, clock, reset, req_tvalid && req_tready && req_tuser |=> !req_tready, "data transfer did not occupy the round unit")

   `SM4C_ASSERT(a_count_range, clock, reset, rsp_tvalid |-> rsp_tdata[132:128] <= 5'd16, "result byte count above sixteen")

   `SM4C_ASSERT(a_low_masked, clock, reset, rsp_tvalid && (rsp_tdata[132:128] <= 5'd8) |-> rsp_tdata[127:64] == 64'd0, "bytes past the count not zero")

   `SM4C_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready, "block not idle after reset")

endmodule

bind sm4_ctr_cipher sm4c_checker u_sm4c_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/testbench.sv -----
// Testbench for the SM4 counter-mode cipher: directed and random traffic against a local model.
`timescale 1ns / 1ps

module testbench
   import sm4c_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;

   // S-box rows, entry 0 in the top byte of the first row.
   localparam logic [0:255][7:0] CIPHER_SBOX = {
      128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
      128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
      128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
      128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
      128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
      128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
      128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
      128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
   };

   typedef struct {
      op_type      op;
      logic [4:0]  key_index;
      logic [31:0] key_word;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic [4:0]  byte_count;
      logic        first_chunk;
   } chunk_req_type;

   typedef struct {
      logic [63:0] result_high;
      logic [63:0] result_low;
      logic [4:0]  result_bytes;
   } chunk_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic                  csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   // Local copy of the cipher state.
   logic [31:0]   round_keys [32];
   logic [127:0]  counter_init;
   logic [127:0]  counter_now;
   chunk_rsp_type pending_ciphertext [$];

   int send_idle_pct;
   int rsp_stall_pct;
   int mismatch_count;
   int cycle_count;

   sm4_ctr_cipher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] round_mix(input logic [31:0] a);
      logic [31:0] b;
      b = {CIPHER_SBOX[a[31:24]], CIPHER_SBOX[a[23:16]], CIPHER_SBOX[a[15:8]],
           CIPHER_SBOX[a[7:0]]};
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
               ^ {b[7:0], b[31:8]};
   endfunction

   function automatic logic [127:0] encrypt_counter(input logic [127:0] blk);
      logic [31:0] x0, x1, x2, x3, nx;
      {x0, x1, x2, x3} = blk;
      for (int r = 0; r < 32; r++) begin
         nx = x0 ^ round_mix(x1 ^ x2 ^ x3 ^ round_keys[r]);
         x0 = x1;
         x1 = x2;
         x2 = x3;
         x3 = nx;
      end
      // final reverse transform
      return {x3, x2, x1, x0};
   endfunction

   function automatic void predict_chunk(input chunk_req_type it);
      chunk_rsp_type exp_rsp;
      logic [4:0]    n;
      logic [127:0]  keystream, mask;
      if (it.op == OP_KEY_LOAD) begin
         round_keys[it.key_index] = it.key_word;
         return;
      end
      if (it.first_chunk)
         counter_now = counter_init;
      n = (it.byte_count > 5'd16) ? 5'd16 : it.byte_count;
      exp_rsp = '{64'd0, 64'd0, 5'd0};
      if (n != 5'd0) begin
         keystream   = encrypt_counter(counter_now);
         counter_now = counter_now + 128'd1;
         mask        = ~128'd0 << (8 * (16 - n));
         {exp_rsp.result_high, exp_rsp.result_low} =
            ({it.data_high, it.data_low} ^ keystream) & mask;
         exp_rsp.result_bytes = n;
      end
      pending_ciphertext.push_back(exp_rsp);
   endfunction

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      chunk_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.result_high  = rsp_tdata[63:0];
         got.result_low   = rsp_tdata[127:64];
         got.result_bytes = rsp_tdata[132:128];
         if (pending_ciphertext.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result with nothing pending: %h %h %0d",
                        got.result_high, got.result_low, got.result_bytes);
         end else begin
            want = pending_ciphertext.pop_front();
            if (got.result_high !== want.result_high || got.result_low !== want.result_low
                || got.result_bytes !== want.result_bytes) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected %h %h %0d, got %h %h %0d",
                           want.result_high, want.result_low, want.result_bytes,
                           got.result_high, got.result_low, got.result_bytes);
            end
         end
      end
   end

   // Returns right after the accepting edge; valid stays up until the next call or a drain.
   task automatic send_item(input chunk_req_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {5'd0, it.first_chunk, it.byte_count, it.data_low, it.data_high,
                     it.key_word, it.key_index};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_chunk(it);
   endtask

   // Hold the sender off until every pending result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_ciphertext.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_counter_init(input logic [63:0] hi, input logic [63:0] lo);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_COUNTER_INIT_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_index <= CSR_COUNTER_INIT_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_we <= 1'b0;
      counter_init = {hi, lo};
   endtask

   function automatic chunk_req_type key_item(input logic [4:0] idx, input logic [31:0] word);
      chunk_req_type it;
      it = '{OP_KEY_LOAD, idx, word, {$urandom, $urandom}, {$urandom, $urandom},
             5'($urandom), 1'($urandom)};
      return it;
   endfunction

   function automatic chunk_req_type data_item(input logic [63:0] hi, input logic [63:0] lo,
                                               input logic [4:0] count, input logic first);
      chunk_req_type it;
      it = '{OP_DATA, 5'($urandom), $urandom, hi, lo, count, first};
      return it;
   endfunction

   function automatic chunk_req_type random_item();
      chunk_req_type it;
      int            sel;
      logic [4:0]    count;
      sel = $urandom_range(9);
      if (sel == 0)
         count = 5'd0;
      else if (sel == 1)
         count = 5'($urandom_range(31, 17));
      else if (sel == 2)
         count = 5'd16;
      else
         count = 5'($urandom_range(16, 1));
      if ($urandom_range(99) < 12)
         it = key_item(5'($urandom), $urandom);
      else
         it = data_item({$urandom, $urandom}, {$urandom, $urandom}, count,
                        $urandom_range(5) == 0);
      return it;
   endfunction

   // Fill every key slot before any data transfer reads one.
   task automatic test_key_load();
      for (int i = 0; i < 32; i++) begin
         if (i == 0)
            send_item(key_item(5'(i), 32'h0000_0000));
         else if (i == 31)
            send_item(key_item(5'(i), 32'hffff_ffff));
         else
            send_item(key_item(5'(i), $urandom));
      end
      drain();
   endtask

   task automatic test_byte_counts();
      write_counter_init(64'd0, 64'd0);
      send_item(data_item(~64'd0, ~64'd0, 5'd16, 1'b1));
      send_item(data_item(64'd0, 64'd0, 5'd1, 1'b0));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd8, 1'b0));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd9, 1'b0));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd15, 1'b0));
      // zero count without first_chunk: no advance and no reload
      send_item(data_item(~64'd0, ~64'd0, 5'd0, 1'b0));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd17, 1'b0));
      send_item(data_item(~64'd0, ~64'd0, 5'd31, 1'b0));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 1'b1));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0));
      // key change between data transfers
      send_item(key_item(5'($urandom), $urandom));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd12, 1'b0));
      drain();
   endtask

   task automatic test_counter_wrap();
      write_counter_init(~64'd0, ~64'd0);
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b1));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0));
      drain();
      // carry out of the low half
      write_counter_init(64'h0123_4567_89ab_cdef, ~64'd0);
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd4, 1'b1));
      send_item(data_item({$urandom, $urandom}, {$urandom, $urandom}, 5'd4, 1'b0));
      drain();
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
      int mode;
      mode = $urandom_range(2);
      if (mode == 0)
         write_counter_init({$urandom, $urandom}, {$urandom, $urandom});
      else if (mode == 1)
         write_counter_init({$urandom, $urandom}, ~64'd0 - 64'($urandom_range(3)));
      else
         write_counter_init(~64'd0, ~64'd0 - 64'($urandom_range(3)));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_item(random_item());
      drain();
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = OP_KEY_LOAD;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_COUNTER_INIT_HIGH;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      counter_init   = '0;
      counter_now    = '0;
      foreach (round_keys[i]) round_keys[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_key_load();
      test_byte_counts();
      test_counter_wrap();
      test_random_phase(0, 0, 95);
      test_random_phase(77, 0, 95);
      test_random_phase(0, 77, 95);
      test_random_phase(14, 14, 95);

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
